>>> rtl/matrix4x4_multiply_defines.svh
// Assertion macros shared by the matrix multiplier RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef MATRIX4X4_MULTIPLY_DEFINES_SVH
`define MATRIX4X4_MULTIPLY_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define MM4_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Implication checked in the cycle after the trigger.
`define MM4_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mm4_pkg.sv
// Shared constants, types and the saturation function of the matrix multiplier.
// Depends on nothing; imported by every module of the block.
package mm4_pkg;

    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;
    localparam int ELEM_W    = 32;
    localparam int IDX_W     = $clog2(DIM);
    localparam int ADDR_W    = $clog2(DIM * DIM);
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = PROD_W - FRAC_BITS + $clog2(DIM);
    localparam int POS_W     = 2;
    localparam int OP_W      = 2;

    localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE    = 2'd2;

    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [POS_W-1:0]         pos_t;
    typedef logic [OP_W-1:0]          op_t;
    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    // Tag that travels with one operand pair through the multiply-accumulate unit.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

    // Clamp the exact dot product to the signed element range.
    function automatic elem_t sat_elem(input acc_t acc);
        logic [ACC_W-ELEM_W:0] upper;
        elem_t                 res;
        begin
            upper = acc[ACC_W-1:ELEM_W-1];
            if ((&upper) || !(|upper)) begin
                res = acc[ELEM_W-1:0];
            end else if (acc[ACC_W-1]) begin
                res = {1'b1, {(ELEM_W-1){1'b0}}};
            end else begin
                res = {1'b0, {(ELEM_W-1){1'b1}}};
            end
            return res;
        end
    endfunction

endpackage

>>> rtl/mm4_store.sv
// One matrix store: memory with a write port, a registered read port and
// per-entry valid bits so that unwritten entries read as zero. Uses mm4_pkg.
module mm4_store (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_en,
    input  mm4_pkg::addr_t wr_addr,
    input  mm4_pkg::elem_t wr_data,
    input  mm4_pkg::addr_t rd_addr,
    output mm4_pkg::elem_t rd_data
);
    import mm4_pkg::*;

    elem_t                mem_reg [DIM*DIM];
    logic [DIM*DIM-1:0]   valid_reg;
    elem_t                rd_mem_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_mem_reg <= mem_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_mem_reg : '0;

endmodule

>>> rtl/mm4_mac.sv
// Shared multiply-accumulate unit: registered product, then shift and exact sum.
// Uses mm4_pkg for widths, the control tag and the saturation function.
module mm4_mac (
    input  logic              aclk,
    input  logic              aresetn,
    input  mm4_pkg::mac_ctl_t ctl,
    input  mm4_pkg::elem_t    a,
    input  mm4_pkg::elem_t    b,
    output logic              acc_done,
    output mm4_pkg::elem_t    result
);
    import mm4_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] shifted;
    mac_ctl_t                 p_ctl_reg;
    acc_t                     term;
    acc_t                     acc_reg;
    acc_t                     acc_next;
    logic                     done_reg;
    logic                     done_next;

    // The arithmetic shift floors, as the fixed-point format requires.
    assign shifted = prod_reg >>> FRAC_BITS;
    assign term    = ACC_W'(shifted);

    always_comb begin
        acc_next = acc_reg;
        if (p_ctl_reg.valid) begin
            acc_next = p_ctl_reg.first ? term : acc_t'(acc_reg + term);
        end
        done_next = done_reg;
        if (ctl.valid && ctl.first) begin
            done_next = 1'b0;
        end else if (p_ctl_reg.valid && p_ctl_reg.last) begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
        acc_reg  <= acc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_ctl_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            p_ctl_reg <= ctl;
            done_reg  <= done_next;
        end
    end

    assign acc_done = done_reg;
    assign result   = sat_elem(acc_reg);

endmodule

>>> rtl/matrix4x4_multiply.sv
// Top level of the 4x4 signed Q16.16 matrix multiplier: request sequencer,
// two matrix stores and one shared multiply-accumulate unit.
// Depends on mm4_pkg, mm4_store, mm4_mac and matrix4x4_multiply_defines.svh.
//
//  Channel | Direction | Ports                                         | Carries
//  s_      | in        | s_valid/s_ready, s_operation, s_row_index,    | load or compute request
//          |           | s_col_index, s_element_value                  |
//  m_      | out       | m_valid/m_ready, m_out_row, m_out_col,        | one product element
//          |           | m_product_value, m_last_of_run                |
//
// A load request produces no result.
// A compute request emits DIM*DIM results in row-major order. For each element,
// DIM operand pairs go through the one shared multiplier, then the store read
// register, product register and accumulator register drain before the element
// can go to the output register.
// A stalled output holds the sequencer before the next element is issued; s_ready
// is high only while no compute request is being worked on.
// Reset is synchronous and active low; both stores read as zero after reset
// through per-entry valid bits, so no clearing pass is needed.
`include "matrix4x4_multiply_defines.svh"

module matrix4x4_multiply (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mm4_pkg::op_t   s_operation,
    input  mm4_pkg::pos_t  s_row_index,
    input  mm4_pkg::pos_t  s_col_index,
    input  mm4_pkg::elem_t s_element_value,
    output logic           m_valid,
    input  logic           m_ready,
    output mm4_pkg::pos_t  m_out_row,
    output mm4_pkg::pos_t  m_out_col,
    output mm4_pkg::elem_t m_product_value,
    output logic           m_last_of_run
);
    import mm4_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_RESULT
    } state_t;

    state_t   state_reg, state_next;
    idx_t     r_reg, r_next;
    idx_t     c_reg, c_next;
    idx_t     k_reg, k_next;
    mac_ctl_t ctl_reg, ctl_next;
    logic     m_valid_reg, m_valid_next;
    pos_t     m_row_reg, m_row_next;
    pos_t     m_col_reg, m_col_next;
    elem_t    m_value_reg, m_value_next;
    logic     m_last_reg, m_last_next;

    logic     in_fire;
    logic     in_range;
    logic     wr_left;
    logic     wr_right;
    addr_t    wr_addr;
    addr_t    left_rd_addr;
    addr_t    right_rd_addr;
    elem_t    left_data;
    elem_t    right_data;
    logic     acc_done;
    elem_t    mac_result;
    logic     out_free;
    logic     load_out;
    logic     last_elem;

    // Request acceptance and the store write path. Loads outside the matrix and
    // the unused operation code are accepted and dropped.
    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign in_range = (int'(s_row_index) < DIM) && (int'(s_col_index) < DIM);
    assign wr_left  = in_fire && in_range && (s_operation == OP_LOAD_LEFT);
    assign wr_right = in_fire && in_range && (s_operation == OP_LOAD_RIGHT);
    assign wr_addr  = ADDR_W'(ADDR_W'(s_row_index) * ADDR_W'(DIM) + ADDR_W'(s_col_index));

    // The left operand walks along row r, the right one down column c.
    assign left_rd_addr  = ADDR_W'(ADDR_W'(r_reg) * ADDR_W'(DIM) + ADDR_W'(k_reg));
    assign right_rd_addr = ADDR_W'(ADDR_W'(k_reg) * ADDR_W'(DIM) + ADDR_W'(c_reg));

    assign last_elem = (r_reg == idx_t'(DIM - 1)) && (c_reg == idx_t'(DIM - 1));
    assign out_free  = !m_valid_reg || m_ready;
    assign load_out  = (state_reg == ST_RESULT) && acc_done && out_free;

    mm4_store u_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_left),
        .wr_addr (wr_addr),
        .wr_data (s_element_value),
        .rd_addr (left_rd_addr),
        .rd_data (left_data)
    );

    mm4_store u_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_right),
        .wr_addr (wr_addr),
        .wr_data (s_element_value),
        .rd_addr (right_rd_addr),
        .rd_data (right_data)
    );

    // The tag register lines up with the registered store read data.
    mm4_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl_reg),
        .a        (left_data),
        .b        (right_data),
        .acc_done (acc_done),
        .result   (mac_result)
    );

    always_comb begin
        state_next   = state_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        k_next       = k_reg;
        ctl_next     = '0;
        m_valid_next = m_valid_reg && !m_ready;
        m_row_next   = m_row_reg;
        m_col_next   = m_col_reg;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire && (s_operation == OP_COMPUTE)) begin
                    state_next = ST_ISSUE;
                    r_next     = '0;
                    c_next     = '0;
                    k_next     = '0;
                end
            end
            ST_ISSUE: begin
                // One operand pair per cycle into the shared multiplier.
                ctl_next.valid = 1'b1;
                ctl_next.first = (k_reg == '0);
                ctl_next.last  = (k_reg == idx_t'(DIM - 1));
                if (k_reg == idx_t'(DIM - 1)) begin
                    k_next     = '0;
                    state_next = ST_RESULT;
                end else begin
                    k_next = idx_t'(k_reg + 1'b1);
                end
            end
            ST_RESULT: begin
                // Wait for the sum to settle and for room in the output register.
                if (load_out) begin
                    m_valid_next = 1'b1;
                    m_row_next   = pos_t'(r_reg);
                    m_col_next   = pos_t'(c_reg);
                    m_value_next = mac_result;
                    m_last_next  = last_elem;
                    if (last_elem) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_ISSUE;
                        if (c_reg == idx_t'(DIM - 1)) begin
                            c_next = '0;
                            r_next = idx_t'(r_reg + 1'b1);
                        end else begin
                            c_next = idx_t'(c_reg + 1'b1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            r_reg       <= '0;
            c_reg       <= '0;
            k_reg       <= '0;
            ctl_reg     <= '0;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            r_reg       <= r_next;
            c_reg       <= c_next;
            k_reg       <= k_next;
            ctl_reg     <= ctl_next;
            m_valid_reg <= m_valid_next;
            m_last_reg  <= m_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_row_reg   <= m_row_next;
        m_col_reg   <= m_col_next;
        m_value_reg <= m_value_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_out_row       = m_row_reg;
    assign m_out_col       = m_col_reg;
    assign m_product_value = m_value_reg;
    assign m_last_of_run   = m_last_reg;

    `MM4_ASSERT_NEXT(a_compute_starts, in_fire && (s_operation == OP_COMPUTE), (state_reg == ST_ISSUE) && (r_reg == '0) && (c_reg == '0) && (k_reg == '0), "compute request did not start at element zero")
    `MM4_ASSERT(a_last_position, !(m_valid && m_last_of_run) || ((m_out_row == pos_t'(DIM - 1)) && (m_out_col == pos_t'(DIM - 1))), "last flag on an element other than the final one")
    `MM4_ASSERT_NEXT(a_last_to_idle, load_out && last_elem, (state_reg == ST_IDLE) && m_valid && m_last_of_run, "final element did not end the run")
    `MM4_ASSERT(a_no_issue_in_result, !((state_reg == ST_RESULT) && ctl_next.valid), "operand issued while waiting for a result")

endmodule

>>> sim/tb_matrix4x4_multiply.sv
// Self-checking testbench for the 4x4 signed Q16.16 matrix multiplier.
// It predicts every product element from its own copy of both matrix stores.
// Depends on mm4_pkg and the matrix4x4_multiply RTL; reads no files.
module tb_matrix4x4_multiply;
    import mm4_pkg::*;

    // Shape of the matrices and of the fixed-point format as the predictor sees them.
    localparam int MAT_DIM = 4;
    localparam int FRAC    = 16;
    localparam longint ELEM_MAX = 2147483647;
    localparam longint ELEM_MIN = -ELEM_MAX - 1;

    // The package names three operations; the fourth code must be ignored by the block.
    localparam op_t OP_UNUSED = 2'd3;

    // Long enough for every random phase even with heavy stalls on both sides.
    localparam int RUN_LIMIT = 1_200_000;

    // Cycles to watch for stray results once nothing is expected.
    localparam int QUIET_CYCLES = 200;

    typedef struct {
        op_t   op;
        pos_t  row;
        pos_t  col;
        elem_t value;
    } mm_request_t;

    typedef struct {
        pos_t  row;
        pos_t  col;
        elem_t value;
        logic  last;
    } product_elem_t;

    logic  aclk;
    logic  aresetn         = 1'b0;
    logic  s_valid         = 1'b0;
    logic  s_ready;
    op_t   s_operation     = OP_LOAD_LEFT;
    pos_t  s_row_index     = '0;
    pos_t  s_col_index     = '0;
    elem_t s_element_value = '0;
    logic  m_valid;
    logic  m_ready         = 1'b0;
    pos_t  m_out_row;
    pos_t  m_out_col;
    elem_t m_product_value;
    logic  m_last_of_run;

    // Requests waiting to be presented, and product elements waiting to come out.
    mm_request_t   request_queue[$];
    product_elem_t pending_products[$];

    // The predictor's own copy of both stores, row-major, cleared like the block.
    elem_t left_store[MAT_DIM*MAT_DIM];
    elem_t right_store[MAT_DIM*MAT_DIM];

    // Idle and stall percentages of the current phase.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int error_count   = 0;

    matrix4x4_multiply dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_row_index    (s_row_index),
        .s_col_index    (s_col_index),
        .s_element_value(s_element_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_row      (m_out_row),
        .m_out_col      (m_out_col),
        .m_product_value(m_product_value),
        .m_last_of_run  (m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        for (int i = 0; i < MAT_DIM*MAT_DIM; i++) begin
            left_store[i]  = '0;
            right_store[i] = '0;
        end
    end

    // One product element: each term is shifted with floor rounding, the sum is
    // exact in 64 bits, and only the final sum is clamped to the element range.
    function automatic elem_t dot_element(int r, int c);
        longint sum;
        longint a;
        longint b;
        sum = 0;
        for (int k = 0; k < MAT_DIM; k++) begin
            a = left_store[r*MAT_DIM + k];
            b = right_store[k*MAT_DIM + c];
            sum += (a * b) >>> FRAC;
        end
        if (sum > ELEM_MAX) begin
            return elem_t'(ELEM_MAX[31:0]);
        end else if (sum < ELEM_MIN) begin
            return elem_t'(ELEM_MIN[31:0]);
        end
        return elem_t'(sum[31:0]);
    endfunction

    // Update the stores for an accepted load, or queue the full product for a compute.
    function automatic void apply_request(op_t op, pos_t row, pos_t col, elem_t value);
        product_elem_t elem;
        case (op)
            OP_LOAD_LEFT: begin
                left_store[row*MAT_DIM + col] = value;
            end
            OP_LOAD_RIGHT: begin
                right_store[row*MAT_DIM + col] = value;
            end
            OP_COMPUTE: begin
                for (int r = 0; r < MAT_DIM; r++) begin
                    for (int c = 0; c < MAT_DIM; c++) begin
                        elem.row   = pos_t'(r);
                        elem.col   = pos_t'(c);
                        elem.value = dot_element(r, c);
                        elem.last  = (r == MAT_DIM-1) && (c == MAT_DIM-1);
                        pending_products.push_back(elem);
                    end
                end
            end
            default: begin
                // The unused code leaves everything as it was.
            end
        endcase
    endfunction

    // Request driver: predicts on every accepted request, then either presents the
    // next queued request or idles, but never drops a request that is still waiting.
    always @(posedge aclk) begin : drive_requests
        mm_request_t next_req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_request(s_operation, s_row_index, s_col_index, s_element_value);
            end
            if (!s_valid || s_ready) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = request_queue.pop_front();
                    s_valid         <= 1'b1;
                    s_operation     <= next_req.op;
                    s_row_index     <= next_req.row;
                    s_col_index     <= next_req.col;
                    s_element_value <= next_req.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: every accepted element must match the oldest prediction.
    always @(posedge aclk) begin : check_products
        product_elem_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_products.size() == 0) begin
                    $error("unexpected product element row %0d col %0d value %h",
                           m_out_row, m_out_col, m_product_value);
                    error_count++;
                end else begin
                    want = pending_products.pop_front();
                    if (m_out_row !== want.row) begin
                        $error("out_row: expected %0d, got %0d", want.row, m_out_row);
                        error_count++;
                    end
                    if (m_out_col !== want.col) begin
                        $error("out_col: expected %0d, got %0d", want.col, m_out_col);
                        error_count++;
                    end
                    if (m_product_value !== want.value) begin
                        $error("product_value: expected %h, got %h",
                               want.value, m_product_value);
                        error_count++;
                    end
                    if (m_last_of_run !== want.last) begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last, m_last_of_run);
                        error_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic push_request(op_t op, pos_t row, pos_t col, elem_t value);
        mm_request_t req;
        req.op    = op;
        req.row   = row;
        req.col   = col;
        req.value = value;
        request_queue.push_back(req);
    endtask

    // Element values: raw bit patterns, small fractions, the extremes, and whole
    // numbers big enough that some dot products saturate.
    function automatic elem_t random_element();
        case ($urandom_range(3))
            0: return elem_t'($urandom);
            1: return elem_t'(int'($urandom_range(0, 1048575)) - 524288);
            2: begin
                case ($urandom_range(4))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0000_0000;
                    3: return 32'shFFFF_FFFF;
                    default: return 32'sh0001_0000;
                endcase
            end
            default: return elem_t'((int'($urandom_range(0, 400)) - 200) <<< FRAC);
        endcase
    endfunction

    // Mostly runs of loads closed by a compute; some runs stop without one, and an
    // unused code is sprinkled in now and then. Ignored requests are not counted.
    task automatic queue_random(int n_items);
        int counted;
        int n_loads;
        counted = 0;
        while (counted < n_items) begin
            n_loads = $urandom_range(1, 16);
            repeat (n_loads) begin
                if ($urandom_range(15) == 0) begin
                    push_request(OP_UNUSED, pos_t'($urandom_range(3)),
                                 pos_t'($urandom_range(3)), elem_t'($urandom));
                end
                push_request($urandom_range(1) ? OP_LOAD_RIGHT : OP_LOAD_LEFT,
                             pos_t'($urandom_range(3)), pos_t'($urandom_range(3)),
                             random_element());
                counted++;
            end
            if ($urandom_range(5) != 0) begin
                push_request(OP_COMPUTE, pos_t'($urandom_range(3)),
                             pos_t'($urandom_range(3)), elem_t'($urandom));
                counted++;
            end
        end
    endtask

    task automatic wait_accepted();
        while (request_queue.size() != 0 || s_valid) @(negedge aclk);
    endtask

    task automatic wait_drained();
        wait_accepted();
        while (pending_products.size() != 0) @(negedge aclk);
    endtask

    // One idling setting, fed in chunks; sometimes the sender waits for the last
    // product of a chunk before going on.
    task automatic run_phase(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        repeat (3) begin
            queue_random(14);
            wait_accepted();
            if ($urandom_range(2) == 0) begin
                wait_drained();
            end
        end
    endtask

    initial begin : stimulus
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Product of the cleared stores is all zero.
        push_request(OP_COMPUTE, 2'd0, 2'd0, 32'sh0);
        // Row 0 at the largest value and row 1 at the smallest, against column 0
        // at the smallest: drives both ends of the saturation.
        for (int k = 0; k < MAT_DIM; k++) begin
            push_request(OP_LOAD_LEFT, 2'd0, pos_t'(k), 32'sh7FFF_FFFF);
            push_request(OP_LOAD_LEFT, 2'd1, pos_t'(k), 32'sh8000_0000);
            push_request(OP_LOAD_RIGHT, pos_t'(k), 2'd0, 32'sh8000_0000);
        end
        // A tiny negative product has to round down to minus one.
        push_request(OP_LOAD_LEFT, 2'd2, 2'd1, 32'shFFFF_FFFF);
        push_request(OP_LOAD_RIGHT, 2'd1, 2'd1, 32'sh0000_0001);
        push_request(OP_LOAD_RIGHT, 2'd3, 2'd3, 32'sh0001_0000);
        push_request(OP_LOAD_LEFT, 2'd3, 2'd3, 32'sh0001_0000);
        // The unused code must not touch the stores; compute ignores its other fields.
        push_request(OP_UNUSED, 2'd3, 2'd3, 32'sh1234_5678);
        push_request(OP_COMPUTE, 2'd3, 2'd3, 32'shFFFF_FFFF);
        wait_drained();

        run_phase(0, 0);
        run_phase(71, 0);
        run_phase(0, 71);
        run_phase(9, 9);

        wait_drained();
        stall_pct = 0;
        repeat (QUIET_CYCLES) @(negedge aclk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #RUN_LIMIT;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
